>>> hdl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared constants, codes and the CRC-16/MODBUS byte update for the sensor
// read response decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

	// Field widths
	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 16;
	localparam int STAT_W  = 3;
	localparam int POS_W   = 3;
	localparam int CFG_IDX_W = 2;

	// Frame header values
	localparam logic [BYTE_W-1:0] FUNC_CODE  = 8'h03;
	localparam logic [BYTE_W-1:0] BYTE_COUNT = 8'h04;

	// CRC-16/MODBUS
	localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_FUNC     = 3'd1;
	localparam logic [STAT_W-1:0] ST_COUNT    = 3'd2;
	localparam logic [STAT_W-1:0] ST_CRC      = 3'd3;
	localparam logic [STAT_W-1:0] ST_HUMIDITY = 3'd4;
	localparam logic [STAT_W-1:0] ST_TEMP     = 3'd5;

	// Byte positions within the frame
	localparam logic [POS_W-1:0] POS_FUNC   = 3'd0;
	localparam logic [POS_W-1:0] POS_COUNT  = 3'd1;
	localparam logic [POS_W-1:0] POS_HUM_HI = 3'd2;
	localparam logic [POS_W-1:0] POS_HUM_LO = 3'd3;
	localparam logic [POS_W-1:0] POS_TMP_HI = 3'd4;
	localparam logic [POS_W-1:0] POS_TMP_LO = 3'd5;
	localparam logic [POS_W-1:0] POS_CRC_LO = 3'd6;
	localparam logic [POS_W-1:0] POS_CRC_HI = 3'd7;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HUM_MAX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TMP_MIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TMP_MAX = 2'd2;

	// Register reset values
	localparam logic        [WORD_W-1:0] HUM_MAX_RST = 16'd1000;
	localparam logic signed [WORD_W-1:0] TMP_MIN_RST = -16'sd400;
	localparam logic signed [WORD_W-1:0] TMP_MAX_RST = 16'sd1250;

	// Fold one byte into the CRC, LSB first
	function automatic logic [WORD_W-1:0] crc_byte(
		input logic [WORD_W-1:0] crc_in,
		input logic [BYTE_W-1:0] data
	);
		logic [WORD_W-1:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> hdl/htfd_ifs.sv
// ----------------------------------------------------------------------------
// htfd channel interfaces
// Valid/ready channels for received bytes, decoded results and register writes.
// ----------------------------------------------------------------------------
interface htfd_byte_if;
	import htfd_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              frame_start;
	modport source (output valid, rx_byte, frame_start, input ready);
	modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface htfd_result_if;
	import htfd_pkg::*;
	logic                     valid;
	logic                     ready;
	logic        [STAT_W-1:0] status;
	logic        [WORD_W-1:0] humidity_tenths;
	logic signed [WORD_W-1:0] temperature_tenths;
	modport source (output valid, status, humidity_tenths, temperature_tenths,
		input ready);
	modport sink   (input valid, status, humidity_tenths, temperature_tenths,
		output ready);
endinterface

interface htfd_cfg_if;
	import htfd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/humidity_temp_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_top
// Decodes the 8-byte sensor read response: header check, CRC-16/MODBUS,
// humidity and sign-magnitude temperature extraction with range checks.
//
//   channel  | dir | payload                                        | width
//   ---------+-----+------------------------------------------------+------
//   rx       | in  | rx_byte, frame_start                           | 8+1
//   res      | out | status, humidity_tenths, temperature_tenths    | 3+16+16
//   cfg      | in  | index, data (register write)                   | 2+16
//
// One byte is taken per cycle unless the input stage stalls. Each byte is held
// in the input register, then the CRC step and the checks update the frame
// state; the eighth byte loads the result register from the input register,
// so a result passes the input register and the result register. Reset clears
// the frame state and loads the register defaults. A result waiting in the
// output register stalls the input stage only when the next eighth byte needs
// that register.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_top (
	input  logic         clk,
	input  logic         arst_n,
	htfd_byte_if.sink    rx,
	htfd_result_if.source res,
	htfd_cfg_if.sink     cfg
);
	import htfd_pkg::*;

	// Configuration registers
	logic        [WORD_W-1:0] hum_max_q;
	logic signed [WORD_W-1:0] tmp_min_q;
	logic signed [WORD_W-1:0] tmp_max_q;

	// Input register
	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              start_s1;

	// Frame state
	logic [POS_W-1:0]  pos_q;
	logic [WORD_W-1:0] crc_q;
	logic [STAT_W-1:0] err_q;
	logic [31:0]       payload_q;
	logic [BYTE_W-1:0] crc_lo_q;

	// Result register
	logic                     res_v_q;
	logic        [STAT_W-1:0] res_status_q;
	logic        [WORD_W-1:0] res_hum_q;
	logic signed [WORD_W-1:0] res_tmp_q;

	// Stage logic
	logic [POS_W-1:0]  pos_eff;
	logic [WORD_W-1:0] crc_eff;
	logic [STAT_W-1:0] err_eff;
	logic [WORD_W-1:0] crc_next;
	logic [STAT_W-1:0] err_next;
	logic [STAT_W-1:0] status_fin;
	logic [WORD_W-1:0] hum_w;
	logic [WORD_W-1:0] traw_w;
	logic signed [WORD_W-1:0] temp_w;
	logic last_byte;
	logic out_free;
	logic adv_s1;
	logic fire_s1;
	logic emit;

	// Configuration writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hum_max_q <= HUM_MAX_RST;
			tmp_min_q <= TMP_MIN_RST;
			tmp_max_q <= TMP_MAX_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_HUM_MAX: hum_max_q <= cfg.data;
				REG_TMP_MIN: tmp_min_q <= $signed(cfg.data);
				REG_TMP_MAX: tmp_max_q <= $signed(cfg.data);
				default: ;
			endcase
		end
	end

	// Handshake: the stage moves unless it must emit into a busy output
	assign out_free  = !res_v_q || res.ready;
	assign pos_eff   = start_s1 ? POS_FUNC : pos_q;
	assign last_byte = (pos_eff == POS_CRC_HI);
	assign adv_s1    = !last_byte || out_free;
	assign fire_s1   = v_s1 && adv_s1;
	assign emit      = fire_s1 && last_byte;
	assign rx.ready  = !v_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.ready) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1  <= rx.rx_byte;
			start_s1 <= rx.frame_start;
		end
	end

	// Restart the frame on a start mark
	assign crc_eff  = start_s1 ? CRC_INIT : crc_q;
	assign err_eff  = start_s1 ? ST_OK : err_q;
	assign crc_next = crc_byte(crc_eff, byte_s1);

	// Decode the words and sign-magnitude temperature
	assign hum_w  = payload_q[31:16];
	assign traw_w = payload_q[15:0];
	assign temp_w = traw_w[15] ? -$signed({1'b0, traw_w[14:0]})
		: $signed({1'b0, traw_w[14:0]});

	// Header errors
	always_comb begin
		err_next = err_eff;
		if (err_eff == ST_OK) begin
			if (pos_eff == POS_FUNC && byte_s1 != FUNC_CODE) begin
				err_next = ST_FUNC;
			end else if (pos_eff == POS_COUNT && byte_s1 != BYTE_COUNT) begin
				err_next = ST_COUNT;
			end
		end
	end

	// Final status: earliest error wins
	always_comb begin
		priority if (err_eff != ST_OK) begin
			status_fin = err_eff;
		end else if ({byte_s1, crc_lo_q} != crc_eff) begin
			status_fin = ST_CRC;
		end else if (hum_w > hum_max_q) begin
			status_fin = ST_HUMIDITY;
		end else if (temp_w < tmp_min_q || temp_w > tmp_max_q) begin
			status_fin = ST_TEMP;
		end else begin
			status_fin = ST_OK;
		end
	end

	// Advance frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_FUNC;
			crc_q <= CRC_INIT;
			err_q <= ST_OK;
		end else if (fire_s1) begin
			if (last_byte) begin
				pos_q <= POS_FUNC;
				crc_q <= CRC_INIT;
				err_q <= ST_OK;
			end else begin
				pos_q <= pos_eff + 3'd1;
				crc_q <= (pos_eff == POS_CRC_LO) ? crc_eff : crc_next;
				err_q <= err_next;
			end
		end
	end

	// Capture payload and received CRC low byte
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			unique case (pos_eff)
				POS_HUM_HI: payload_q[31:24] <= byte_s1;
				POS_HUM_LO: payload_q[23:16] <= byte_s1;
				POS_TMP_HI: payload_q[15:8]  <= byte_s1;
				POS_TMP_LO: payload_q[7:0]   <= byte_s1;
				POS_CRC_LO: crc_lo_q         <= byte_s1;
				POS_FUNC, POS_COUNT, POS_CRC_HI: ;
			endcase
		end
	end

	// Result register: load on the eighth byte, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (emit) begin
			res_v_q <= 1'b1;
		end else if (res.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_status_q <= status_fin;
			res_hum_q    <= hum_w;
			res_tmp_q    <= temp_w;
		end
	end

	assign res.valid              = res_v_q;
	assign res.status             = res_status_q;
	assign res.humidity_tenths    = res_hum_q;
	assign res.temperature_tenths = res_tmp_q;

`ifndef ASSERT_OFF
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> res_v_q)
		else $error("eighth byte did not load the result register");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (pos_q == POS_FUNC && crc_q == CRC_INIT && err_q == ST_OK))
		else $error("frame state not restarted after result");

	a_err_position: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK) |-> (pos_q != POS_FUNC))
		else $error("error pending at frame start position");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q |-> (res_status_q <= ST_TEMP))
		else $error("status code out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (v_s1 && last_byte && res_v_q && !res.ready))
		else $error("input stalled without a blocked result");
`endif

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor read response decoder. Byte frames go in
// through the byte channel and decoded readings are compared field by field
// against listed or in-bench decoded readings. A table of directed frames
// covers the header, CRC, range and framing corner cases. Random phases follow,
// each under new limit registers, with bursty input and a stalling result sink.
// ----------------------------------------------------------------------------
module tb_top;
	import htfd_pkg::*;

	// Decoded reading as it leaves the block
	typedef struct packed {
		logic        [STAT_W-1:0] status;
		logic        [WORD_W-1:0] hum;
		logic signed [WORD_W-1:0] temp;
	} reading_t;

	// One frame to send: header bytes, payload words, CRC damage, length
	typedef struct {
		logic [BYTE_W-1:0] func;
		logic [BYTE_W-1:0] count;
		logic [WORD_W-1:0] hum;
		logic [WORD_W-1:0] tmp;
		logic [WORD_W-1:0] crc_flip;
		int                nbytes;
		bit                start;
		bit                known;
		reading_t          want;
	} frame_spec_t;

	typedef enum {SINK_OPEN, SINK_COIN, SINK_TIGHT} sink_mode_t;

	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_BYTES   = 58;

	logic clk = 1'b0;
	logic arst_n;

	htfd_byte_if   rx_if();
	htfd_result_if res_if();
	htfd_cfg_if    cfg_if();

	humidity_temp_frame_decoder_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	// Limit registers as the decoder sees them
	logic        [WORD_W-1:0] lim_hum_max = HUM_MAX_RST;
	logic signed [WORD_W-1:0] lim_tmin    = TMP_MIN_RST;
	logic signed [WORD_W-1:0] lim_tmax    = TMP_MAX_RST;

	// Frame state of the in-bench decoder
	logic [POS_W-1:0]  fr_pos    = POS_FUNC;
	logic [WORD_W-1:0] fr_crc    = CRC_INIT;
	logic [STAT_W-1:0] fr_err    = ST_OK;
	logic [WORD_W-1:0] fr_hum    = '0;
	logic [WORD_W-1:0] fr_tmp    = '0;
	logic [BYTE_W-1:0] fr_crc_lo = '0;

	reading_t   readings_q[$];
	int         mismatches = 0;
	int         bytes_sent = 0;
	int         burst_left = 0;
	bit         cut_pending = 1'b0;
	int         sink_run = 0;
	sink_mode_t sink_mode = SINK_OPEN;

	// Directed frames, checked against reset limits 1000 / -400 / 1250
	frame_spec_t directed_frames [20] = '{
		'{FUNC_CODE, BYTE_COUNT, 16'd500, 16'h00FA, 16'h0000, 8, 1, 1,
			'{ST_OK, 16'd500, 16'sd250}},
		'{8'h00, BYTE_COUNT, 16'd500, 16'h00FA, 16'h0000, 8, 1, 1,
			'{ST_FUNC, 16'd500, 16'sd250}},
		'{8'hFF, 8'hFF, 16'd500, 16'h00FA, 16'h0000, 8, 1, 1,
			'{ST_FUNC, 16'd500, 16'sd250}},
		'{FUNC_CODE, 8'h00, 16'd500, 16'h00FA, 16'h0000, 8, 1, 1,
			'{ST_COUNT, 16'd500, 16'sd250}},
		'{FUNC_CODE, BYTE_COUNT, 16'd500, 16'h00FA, 16'h0001, 8, 1, 1,
			'{ST_CRC, 16'd500, 16'sd250}},
		'{FUNC_CODE, BYTE_COUNT, 16'hFFFF, 16'h00FA, 16'h8000, 8, 1, 1,
			'{ST_CRC, 16'hFFFF, 16'sd250}},
		'{FUNC_CODE, BYTE_COUNT, 16'd1001, 16'h00FA, 16'h0000, 8, 1, 1,
			'{ST_HUMIDITY, 16'd1001, 16'sd250}},
		'{FUNC_CODE, BYTE_COUNT, 16'd1000, 16'h8000, 16'h0000, 8, 1, 1,
			'{ST_OK, 16'd1000, 16'sd0}},
		'{FUNC_CODE, BYTE_COUNT, 16'd0, 16'hFFFF, 16'h0000, 8, 1, 1,
			'{ST_TEMP, 16'd0, -16'sd32767}},
		'{FUNC_CODE, BYTE_COUNT, 16'd0, 16'h7FFF, 16'h0000, 8, 1, 1,
			'{ST_TEMP, 16'd0, 16'sd32767}},
		'{FUNC_CODE, BYTE_COUNT, 16'd0, 16'h8190, 16'h0000, 8, 1, 1,
			'{ST_OK, 16'd0, -16'sd400}},
		'{FUNC_CODE, BYTE_COUNT, 16'd0, 16'h04E2, 16'h0000, 8, 1, 1,
			'{ST_OK, 16'd0, 16'sd1250}},
		'{FUNC_CODE, BYTE_COUNT, 16'd0, 16'h04E3, 16'h0000, 8, 1, 1,
			'{ST_TEMP, 16'd0, 16'sd1251}},
		'{FUNC_CODE, BYTE_COUNT, 16'd0, 16'h8191, 16'h0000, 8, 1, 1,
			'{ST_TEMP, 16'd0, -16'sd401}},
		'{FUNC_CODE, BYTE_COUNT, 16'd2000, 16'hFFFF, 16'h0000, 8, 1, 1,
			'{ST_HUMIDITY, 16'd2000, -16'sd32767}},
		// partial frame cut short by the next frame start
		'{FUNC_CODE, BYTE_COUNT, 16'h0123, 16'h8055, 16'h0000, 3, 1, 0,
			'{ST_OK, 16'd0, 16'sd0}},
		'{FUNC_CODE, BYTE_COUNT, 16'h0123, 16'h8055, 16'h0000, 8, 1, 0,
			'{ST_OK, 16'd0, 16'sd0}},
		// no frame start: the frame follows on from the current position
		'{FUNC_CODE, BYTE_COUNT, 16'h0001, 16'h0001, 16'h0000, 8, 0, 0,
			'{ST_OK, 16'd0, 16'sd0}},
		'{FUNC_CODE, BYTE_COUNT, 16'h0321, 16'h0123, 16'h0000, 6, 1, 0,
			'{ST_OK, 16'd0, 16'sd0}},
		'{FUNC_CODE, BYTE_COUNT, 16'h02A8, 16'h8001, 16'h0000, 8, 1, 0,
			'{ST_OK, 16'd0, 16'sd0}}
	};

	// Clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Fold one byte into a CRC-16/MODBUS, one bit per step, LSB first
	function automatic logic [WORD_W-1:0] crc16_fold(input logic [WORD_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [WORD_W-1:0] c;
		logic              fb;
		c = crc;
		for (int i = 0; i < BYTE_W; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic void keep_first(input logic [STAT_W-1:0] code);
		if (fr_err == ST_OK) begin
			fr_err = code;
		end
	endfunction

	function automatic void frame_restart();
		fr_pos = POS_FUNC;
		fr_crc = CRC_INIT;
		fr_err = ST_OK;
	endfunction

	// Advance the frame decoder by one byte; return 1 when a reading is due
	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic s,
		output reading_t r);
		logic [POS_W-1:0] pos;
		int               t;
		if (s) begin
			frame_restart();
		end
		pos = fr_pos;
		r = '0;
		if (pos < POS_CRC_LO) begin
			fr_crc = crc16_fold(fr_crc, b);
		end
		case (pos)
			POS_FUNC: begin
				if (b != FUNC_CODE) begin
					keep_first(ST_FUNC);
				end
			end
			POS_COUNT: begin
				if (b != BYTE_COUNT) begin
					keep_first(ST_COUNT);
				end
			end
			POS_HUM_HI: fr_hum[15:8] = b;
			POS_HUM_LO: fr_hum[7:0]  = b;
			POS_TMP_HI: fr_tmp[15:8] = b;
			POS_TMP_LO: fr_tmp[7:0]  = b;
			POS_CRC_LO: fr_crc_lo    = b;
			default: ;
		endcase
		if (pos != POS_CRC_HI) begin
			fr_pos = pos + 3'd1;
			return 1'b0;
		end
		if ({b, fr_crc_lo} != fr_crc) begin
			keep_first(ST_CRC);
		end
		// sign-magnitude word; negative zero folds to zero
		t = fr_tmp[15] ? -int'(fr_tmp[14:0]) : int'(fr_tmp[14:0]);
		if (fr_hum > lim_hum_max) begin
			keep_first(ST_HUMIDITY);
		end
		if (t < int'(lim_tmin) || t > int'(lim_tmax)) begin
			keep_first(ST_TEMP);
		end
		r.status = fr_err;
		r.hum    = fr_hum;
		r.temp   = 16'(t);
		frame_restart();
		return 1'b1;
	endfunction

	// Offer one byte; open a gap first when the current burst is used up
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic s,
		input bit typed, input reading_t want);
		reading_t got;
		int       gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 4);
			rx_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		rx_if.valid       <= 1'b1;
		rx_if.rx_byte     <= b;
		rx_if.frame_start <= s;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		if (decode_byte(b, s, got)) begin
			readings_q.push_back(typed ? want : got);
		end
		bytes_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// Serialize a frame with its CRC, possibly damaged or cut short
	task automatic send_frame(input frame_spec_t f);
		logic [BYTE_W-1:0] fb [8];
		logic [WORD_W-1:0] crc;
		fb[0] = f.func;
		fb[1] = f.count;
		fb[2] = f.hum[15:8];
		fb[3] = f.hum[7:0];
		fb[4] = f.tmp[15:8];
		fb[5] = f.tmp[7:0];
		crc = CRC_INIT;
		for (int i = 0; i < 6; i++) begin
			crc = crc16_fold(crc, fb[i]);
		end
		crc = crc ^ f.crc_flip;
		fb[6] = crc[7:0];
		fb[7] = crc[15:8];
		for (int i = 0; i < f.nbytes; i++) begin
			send_byte(fb[i], (i == 0) ? f.start : 1'b0, f.known && (i == 7), f.want);
		end
	endtask

	// Mostly well-formed frame with values aimed at the current limits
	task automatic send_random_frame();
		frame_spec_t f;
		int          h;
		int          t;
		int          lo;
		int          hi;
		f.func  = ($urandom_range(0, 15) == 0) ? 8'($urandom) : FUNC_CODE;
		f.count = ($urandom_range(0, 15) == 0) ? 8'($urandom) : BYTE_COUNT;
		case ($urandom_range(0, 3))
			0: h = $urandom_range(0, 65535);
			1: h = int'(lim_hum_max) + int'($urandom_range(0, 4)) - 2;
			2: h = $urandom_range(0, lim_hum_max);
			default: h = $urandom_range(0, 1000);
		endcase
		h = (h < 0) ? 0 : (h > 65535) ? 65535 : h;
		lo = int'(lim_tmin);
		hi = int'(lim_tmax);
		case ($urandom_range(0, 3))
			0: t = int'($urandom_range(0, 65534)) - 32767;
			1: t = lo + int'($urandom_range(0, 4)) - 2;
			2: t = hi + int'($urandom_range(0, 4)) - 2;
			default: t = (lo <= hi) ? lo + int'($urandom_range(0, hi - lo))
				: int'($urandom_range(0, 200)) - 100;
		endcase
		t = (t < -32767) ? -32767 : (t > 32767) ? 32767 : t;
		f.hum = 16'(h);
		if (t < 0) begin
			f.tmp = {1'b1, 15'(-t)};
		end else begin
			// zero goes out with either sign bit
			f.tmp = {(t == 0) ? 1'($urandom_range(0, 1)) : 1'b0, 15'(t)};
		end
		f.crc_flip = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
		f.nbytes   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : 8;
		f.start    = cut_pending ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 3) != 0);
		f.known    = 1'b0;
		f.want     = '0;
		cut_pending = (f.nbytes < 8);
		send_frame(f);
	endtask

	// Park the byte channel and wait until every reading is out
	task automatic drain();
		rx_if.valid <= 1'b0;
		burst_left = 0;
		while (readings_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write all three limit registers back to back
	task automatic write_limits(input logic [WORD_W-1:0] hum_max,
		input logic signed [WORD_W-1:0] tmin, input logic signed [WORD_W-1:0] tmax);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [WORD_W-1:0]    val [3];
		idx = '{REG_HUM_MAX, REG_TMP_MIN, REG_TMP_MAX};
		val = '{hum_max, tmin, tmax};
		for (int i = 0; i < 3; i++) begin
			cfg_if.valid <= 1'b1;
			cfg_if.index <= idx[i];
			cfg_if.data  <= val[i];
			@(posedge clk);
			while (!cfg_if.ready) @(posedge clk);
			@(negedge clk);
		end
		cfg_if.valid <= 1'b0;
		lim_hum_max = hum_max;
		lim_tmin    = tmin;
		lim_tmax    = tmax;
	endtask

	// Result sink: stall in randomly chosen modes, each held for a random run
	always @(negedge clk) begin
		if (sink_run == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 2));
			sink_run  = $urandom_range(8, 60);
		end else begin
			sink_run--;
		end
		case (sink_mode)
			SINK_OPEN: res_if.ready <= 1'b1;
			SINK_COIN: res_if.ready <= 1'($urandom_range(0, 1));
			default:   res_if.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Check each result transfer against the oldest expected reading
	always @(posedge clk) begin
		reading_t exp_r;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (readings_q.size() == 0) begin
				$display("%0t: unexpected reading status %0d hum %0d temp %0d", $time,
					res_if.status, res_if.humidity_tenths, res_if.temperature_tenths);
				mismatches++;
			end else begin
				exp_r = readings_q.pop_front();
				if (res_if.status !== exp_r.status) begin
					$display("%0t: status expected %0d got %0d", $time, exp_r.status,
						res_if.status);
					mismatches++;
				end
				if (res_if.humidity_tenths !== exp_r.hum) begin
					$display("%0t: humidity expected %0d got %0d", $time, exp_r.hum,
						res_if.humidity_tenths);
					mismatches++;
				end
				if (res_if.temperature_tenths !== exp_r.temp) begin
					$display("%0t: temperature expected %0d got %0d", $time, exp_r.temp,
						res_if.temperature_tenths);
					mismatches++;
				end
			end
		end
	end

	// Hard stop if the run hangs
	initial begin
		#3000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Main sequence
	initial begin
		int stop_at;
		arst_n            = 1'b0;
		rx_if.valid       = 1'b0;
		rx_if.rx_byte     = '0;
		rx_if.frame_start = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = REG_HUM_MAX;
		cfg_if.data       = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames under reset limits
		foreach (directed_frames[i]) begin
			send_frame(directed_frames[i]);
		end

		// random phases, each under its own limits
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: write_limits(HUM_MAX_RST, TMP_MIN_RST, TMP_MAX_RST);
				1: write_limits(16'hFFFF, -16'sd32767, 16'sd32767);
				2: write_limits(16'd0, 16'sd0, 16'sd0);
				3: write_limits(16'd500, 16'sd100, -16'sd100);
				4: write_limits(16'd65535, 16'sd32767, 16'sd32767);
				default: write_limits(16'($urandom), 16'(int'($urandom_range(0, 32767)) - 32767),
					16'($urandom_range(0, 32767)));
			endcase
			cut_pending = 1'b1;
			stop_at = bytes_sent + PHASE_BYTES;
			while (bytes_sent < stop_at) begin
				if ($urandom_range(0, 11) == 0) begin
					// noise: a few raw bytes with random frame starts
					repeat ($urandom_range(1, 5)) begin
						send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
					end
					cut_pending = 1'b1;
				end else begin
					send_random_frame();
				end
			end
		end

		drain();
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/htfd_pkg.sv
hdl/htfd_ifs.sv
hdl/humidity_temp_frame_decoder_top.sv
test/tb_top.sv
